// ===== rtl/sfir_pkg.sv =====
// Shared constants and types of the sorted frame index resolver.
// No dependencies; imported by every module under rtl/.
package sfir_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // probes needed to shrink a span of TABLE_DEPTH entries to nothing
    localparam int NSTEP       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int FRAME_W = 31;
    localparam int TIME_W  = 63;
    localparam int COUNT_W = 11;

    localparam int IN_FIELDS_W  = 1 + IDX_W + 1 + FRAME_W + 1 + TIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = IDX_W + FRAME_W + TIME_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // search window carried from cell to cell
    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] mid;
    } srch_st_t;

endpackage

// ===== rtl/sorted_frame_index_resolver.sv =====
// Sorted frame index resolver: append, clear and floor search on a table
// of (timestamp, frame) pairs. Depends on sfir_pkg, sfir_cell, sfir_table.
// One request at a time. Append, clear, bad commands and index misses go straight
// to the result state; a direct index hit first reads its entry through the
// registered table port, and a key search first runs the NSTEP probe cells sharing
// one read port. Results wait for m_tready. Async reset empties the table.
module sorted_frame_index_resolver
    import sfir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] index_valid, [10:1] entry_index, [11] frame_valid,
    // [42:12] frame_value, [43] time_valid, [106:44] time_value
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      s_tuser,
    // master side result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] found_index, [40:10] found_frame, [103:41] found_time,
    // [114:104] entry_count
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] ok
    output logic [0:0]            m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // request fields
    logic               in_index_valid;
    logic [IDX_W-1:0]   in_entry_index;
    logic               in_frame_valid;
    logic [FRAME_W-1:0] in_frame_value;
    logic               in_time_valid;
    logic [TIME_W-1:0]  in_time_value;

    assign in_index_valid = s_tdata[0];
    assign in_entry_index = s_tdata[IDX_W:1];
    assign in_frame_valid = s_tdata[IDX_W+1];
    assign in_frame_value = s_tdata[IDX_W+FRAME_W+1:IDX_W+2];
    assign in_time_valid  = s_tdata[IDX_W+FRAME_W+2];
    assign in_time_value  = s_tdata[IDX_W+FRAME_W+TIME_W+2:IDX_W+FRAME_W+3];

    state_t              state_reg,   state_next;
    logic [CNT_W-1:0]    fill_reg,    fill_next;
    logic [TIME_W-1:0]   key_reg,     key_next;
    logic                sel_time_reg, sel_time_next;
    logic [ADDR_W-1:0]   fetch_idx_reg, fetch_idx_next;
    logic                res_ok_reg,  res_ok_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [TIME_W-1:0]   res_time_reg,  res_time_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_ok_reg,  out_ok_next;

    // table port
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [FRAME_W-1:0] rd_frame;
    logic [TIME_W-1:0]  rd_time;
    logic [TIME_W-1:0]  rd_key;

    // probe chain
    srch_st_t           start_st;
    srch_st_t           cell_in  [NSTEP];
    srch_st_t           cell_out [NSTEP];
    logic [CNT_W-1:0]   chain_mid;
    logic               last_active;
    logic [CNT_W-1:0]   ub;
    logic [CNT_W-1:0]   ub_prev;

    logic               accept;
    logic               table_full;
    logic               index_hit;
    logic               start_search;

    assign accept     = s_tvalid && (state_reg == ST_IDLE);
    assign table_full = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign index_hit  = 32'(in_entry_index) < 32'(fill_reg);
    assign start_search = accept && (s_tuser == CMD_RESOLVE) && !in_index_valid
                          && (in_frame_valid || in_time_valid) && (fill_reg != '0);

    // the stored frame column compares as a zero-extended key
    assign rd_key = sel_time_reg ? rd_time : {{(TIME_W-FRAME_W){1'b0}}, rd_frame};

    always_comb
    begin
        start_st.active = start_search;
        start_st.first  = '0;
        start_st.len    = fill_reg;
        start_st.mid    = fill_reg >> 1;
    end

    assign cell_in[0] = start_st;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_cell
        if (k > 0)
        begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        sfir_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .in_st  (cell_in[k]),
            .key    (key_reg),
            .rd_key (rd_key),
            .out_st (cell_out[k])
        );
    end

    // only one cell holds a live window, so its next probe wins the OR
    always_comb
    begin
        chain_mid = '0;
        for (int k = 0; k < NSTEP - 1; k++)
        begin
            if (cell_out[k].active)
            begin
                chain_mid = chain_mid | cell_out[k].mid;
            end
        end
    end

    assign last_active = cell_out[NSTEP-1].active;
    assign ub          = cell_out[NSTEP-1].first;
    assign ub_prev     = ub - CNT_W'(1);

    always_comb
    begin
        if (state_reg == ST_SEARCH)
        begin
            rd_addr = last_active ? ub_prev[ADDR_W-1:0] : chain_mid[ADDR_W-1:0];
        end
        else if (in_index_valid)
        begin
            rd_addr = ADDR_W'(in_entry_index);
        end
        else
        begin
            rd_addr = start_st.mid[ADDR_W-1:0];
        end
    end

    assign wr_en = accept && (s_tuser == CMD_APPEND) && !table_full;

    sfir_table u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (fill_reg[ADDR_W-1:0]),
        .wr_frame (in_frame_value),
        .wr_time  (in_time_value),
        .rd_addr  (rd_addr),
        .rd_frame (rd_frame),
        .rd_time  (rd_time)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        key_next       = key_reg;
        sel_time_next  = sel_time_reg;
        fetch_idx_next = fetch_idx_reg;
        res_ok_next    = res_ok_reg;
        res_idx_next   = res_idx_reg;
        res_frame_next = res_frame_reg;
        res_time_next  = res_time_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // failure result unless a branch below says otherwise
                    res_ok_next    = 1'b0;
                    res_idx_next   = '0;
                    res_frame_next = '0;
                    res_time_next  = '0;
                    state_next     = ST_DONE;
                    case (s_tuser)
                        CMD_APPEND:
                        begin
                            if (!table_full)
                            begin
                                res_ok_next    = 1'b1;
                                res_idx_next   = IDX_W'(fill_reg);
                                res_frame_next = in_frame_value;
                                res_time_next  = in_time_value;
                                fill_next      = fill_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            res_ok_next = 1'b1;
                            fill_next   = '0;
                        end
                        CMD_RESOLVE:
                        begin
                            if (in_index_valid)
                            begin
                                if (index_hit)
                                begin
                                    fetch_idx_next = ADDR_W'(in_entry_index);
                                    state_next     = ST_FETCH;
                                end
                            end
                            else if (start_search)
                            begin
                                sel_time_next = !in_frame_valid;
                                key_next      = in_frame_valid
                                              ? {{(TIME_W-FRAME_W){1'b0}}, in_frame_value}
                                              : in_time_value;
                                state_next    = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (last_active)
                begin
                    // floor entry is just before the upper bound
                    if ((ub >= fill_reg) || (ub == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        fetch_idx_next = ub_prev[ADDR_W-1:0];
                        state_next     = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                res_ok_next    = 1'b1;
                res_idx_next   = IDX_W'(fetch_idx_reg);
                res_frame_next = rd_frame;
                res_time_next  = rd_time;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_data_next  = OUT_DATA_W'({COUNT_W'(fill_reg), res_time_reg,
                                                  res_frame_reg, res_idx_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        sel_time_reg  <= sel_time_next;
        fetch_idx_reg <= fetch_idx_next;
        res_ok_reg    <= res_ok_next;
        res_idx_reg   <= res_idx_next;
        res_frame_reg <= res_frame_next;
        res_time_reg  <= res_time_next;
        out_data_reg  <= out_data_next;
        out_ok_reg    <= out_ok_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

endmodule

// ===== rtl/sfir_cell.sv =====
// One probe cell of the search chain: registers the window from its left
// neighbour, compares the probed entry and hands the narrowed window on.
// Depends on sfir_pkg.
module sfir_cell
    import sfir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  srch_st_t          in_st,
    input  logic [TIME_W-1:0] key,
    input  logic [TIME_W-1:0] rd_key,
    output srch_st_t          out_st
);

    srch_st_t         st_reg;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] rfirst;
    logic [CNT_W-1:0] rlen;
    logic             go_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= in_st;
        end
    end

    always_comb
    begin
        half     = st_reg.len >> 1;
        rfirst   = st_reg.mid + CNT_W'(1);
        rlen     = st_reg.len - half - CNT_W'(1);
        go_right = !(key < rd_key);
        out_st   = st_reg;
        if (st_reg.len != '0)
        begin
            if (go_right)
            begin
                out_st.first = rfirst;
                out_st.len   = rlen;
                out_st.mid   = rfirst + (rlen >> 1);
            end
            else
            begin
                out_st.len = half;
                out_st.mid = st_reg.first + (half >> 1);
            end
        end
    end

endmodule

// ===== rtl/sfir_table.sv =====
// Entry store: frame and time columns, one write and one registered read.
// Depends on sfir_pkg.
module sfir_table
    import sfir_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [FRAME_W-1:0] wr_frame,
    input  logic [TIME_W-1:0]  wr_time,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [FRAME_W-1:0] rd_frame,
    output logic [TIME_W-1:0]  rd_time
);

    logic [FRAME_W-1:0] frame_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]  time_mem  [TABLE_DEPTH];
    logic [FRAME_W-1:0] rd_frame_reg;
    logic [TIME_W-1:0]  rd_time_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_frame;
            time_mem[wr_addr]  <= wr_time;
        end
        rd_frame_reg <= frame_mem[rd_addr];
        rd_time_reg  <= time_mem[rd_addr];
    end

    assign rd_frame = rd_frame_reg;
    assign rd_time  = rd_time_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sorted_frame_index_resolver: append, clear, direct-index and floor-search requests.
// Depends on rtl/sfir_pkg.sv and rtl/sorted_frame_index_resolver.sv.
module tb;
    import sfir_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNKNOWN  = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_TOP    = '1;
    localparam logic [TIME_W-1:0]  TIME_TOP     = '1;
    localparam longint unsigned    FRAME_LIMIT  = 64'h7FFF_FFFF;
    localparam longint unsigned    TIME_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int                 HOLD_CYCLES  = 300;
    localparam int                 DRAIN_CYCLES = 40;
    localparam int                 MAX_REPORTS  = 20;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               idx_v;
        logic [IDX_W-1:0]   idx;
        logic               frm_v;
        logic [FRAME_W-1:0] frm;
        logic               tim_v;
        logic [TIME_W-1:0]  tim;
    } request_t;

    typedef struct packed {
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic [FRAME_W-1:0] frm;
        logic [TIME_W-1:0]  tim;
        logic [COUNT_W-1:0] cnt;
    } lookup_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    sorted_frame_index_resolver uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // requests waiting to be offered, and lookups still owed by the block
    request_t pending_requests[$];
    lookup_t  owed_lookups[$];

    // own copy of the table, updated on every accepted request
    logic [TIME_W-1:0]  time_tbl [TABLE_DEPTH];
    logic [FRAME_W-1:0] frame_tbl[TABLE_DEPTH];
    int                 fill_level = 0;

    // keys appended so far by the stimulus, used to aim queries near them
    logic [FRAME_W-1:0] key_frames[$];
    logic [TIME_W-1:0]  key_times[$];

    int   total_requests = 1;
    int   sent_count     = 0;
    logic req_taken      = 1'b0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;
    int   fail_count     = 0;
    int   n_appends = 0, n_refused = 0, n_clears = 0;
    int   n_resolves = 0, n_hits = 0, n_unknown = 0;

    function automatic logic [FRAME_W-1:0] rand_frame();
        return FRAME_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // upper bound: first slot whose key is greater than the query
    function automatic int upper_slot(logic by_time, logic [TIME_W-1:0] q);
        int                lo;
        int                len;
        int                half;
        int                mid;
        logic [TIME_W-1:0] v;
        lo  = 0;
        len = fill_level;
        while (len > 0)
        begin
            half = len / 2;
            mid  = lo + half;
            v    = by_time ? time_tbl[mid] : TIME_W'(frame_tbl[mid]);
            if (!(q < v))
            begin
                lo  = mid + 1;
                len = len - half - 1;
            end
            else
                len = half;
        end
        return lo;
    endfunction

    // apply one request to the table copy and return the lookup it owes
    function automatic lookup_t apply_request(request_t r);
        lookup_t res;
        int      pick;
        int      ub;
        res  = '0;
        pick = -1;
        case (r.cmd)
            CMD_APPEND:
            begin
                if (fill_level >= TABLE_DEPTH)
                    n_refused++;
                else
                begin
                    time_tbl[fill_level]  = r.tim;
                    frame_tbl[fill_level] = r.frm;
                    pick = fill_level;
                    fill_level++;
                    n_appends++;
                end
            end
            CMD_CLEAR:
            begin
                fill_level = 0;
                res.ok     = 1'b1;
                n_clears++;
            end
            CMD_RESOLVE:
            begin
                n_resolves++;
                if (r.idx_v)
                begin
                    if (int'(r.idx) < fill_level)
                        pick = int'(r.idx);
                end
                else if (r.frm_v || r.tim_v)
                begin
                    ub = r.frm_v ? upper_slot(1'b0, TIME_W'(r.frm)) : upper_slot(1'b1, r.tim);
                    // past the last entry or before the first one: no floor
                    if (ub < fill_level && ub != 0)
                        pick = ub - 1;
                end
                if (pick >= 0)
                    n_hits++;
            end
            default:
                n_unknown++;
        endcase
        if (pick >= 0)
        begin
            res.ok  = 1'b1;
            res.idx = IDX_W'(pick);
            res.frm = frame_tbl[pick];
            res.tim = time_tbl[pick];
        end
        res.cnt = COUNT_W'(fill_level);
        return res;
    endfunction

    task automatic flag_field(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic add_req(logic [CMD_W-1:0] cmd, logic iv, logic [IDX_W-1:0] ix,
                           logic fv, logic [FRAME_W-1:0] f, logic tv, logic [TIME_W-1:0] t);
        request_t r;
        r = '{cmd: cmd, idx_v: iv, idx: ix, frm_v: fv, frm: f, tim_v: tv, tim: t};
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // append with junk in the fields an append ignores
    task automatic add_append(logic [FRAME_W-1:0] f, logic [TIME_W-1:0] t);
        add_req(CMD_APPEND, 1'($urandom), IDX_W'($urandom), 1'($urandom), f, 1'($urandom), t);
        key_frames.insert(key_frames.size(), f);
        key_times.insert(key_times.size(), t);
    endtask

    // a stored key, or one just either side of it, now and then anything at all
    function automatic logic [TIME_W-1:0] near_key(logic by_time);
        logic [TIME_W-1:0] k;
        int                j;
        if (key_frames.size() == 0 || $urandom_range(0, 7) == 0)
            return by_time ? rand_time() : TIME_W'(rand_frame());
        j = $urandom_range(0, key_frames.size() - 1);
        k = by_time ? key_times[j] : TIME_W'(key_frames[j]);
        case ($urandom_range(0, 3))
            0: k = k - 1;
            1: k = k + 1;
            default: ;
        endcase
        return k;
    endfunction

    task automatic add_query();
        int               kind;
        logic [IDX_W-1:0] ix;
        kind = $urandom_range(0, 19);
        ix   = IDX_W'($urandom);
        if (kind == 0)
            add_req(CMD_UNKNOWN, 1'($urandom), ix, 1'($urandom), rand_frame(),
                    1'($urandom), rand_time());
        else if (kind < 7)
        begin
            // direct index, mostly around the fill level; other keys may ride along
            if ($urandom_range(0, 3) != 0)
                ix = IDX_W'($urandom_range(0, key_frames.size() + 1));
            add_req(CMD_RESOLVE, 1'b1, ix, 1'($urandom), FRAME_W'(near_key(1'b0)),
                    1'($urandom), near_key(1'b1));
        end
        else if (kind < 12)
            add_req(CMD_RESOLVE, 1'b0, ix, 1'b1, FRAME_W'(near_key(1'b0)),
                    1'($urandom), near_key(1'b1));
        else if (kind < 18)
            add_req(CMD_RESOLVE, 1'b0, ix, 1'b0, FRAME_W'(near_key(1'b0)),
                    1'b1, near_key(1'b1));
        else
            add_req(CMD_RESOLVE, 1'b0, ix, 1'b0, rand_frame(), 1'b0, rand_time());
    endtask

    // one run: usually a clear, then ascending appends with the odd stray pair, then queries
    task automatic build_run();
        int              n_app;
        int              n_q;
        int              i;
        longint unsigned fk;
        longint unsigned tk;
        if ($urandom_range(0, 4) != 0)
        begin
            add_req(CMD_CLEAR, 1'($urandom), IDX_W'($urandom), 1'($urandom), rand_frame(),
                    1'($urandom), rand_time());
            key_frames.delete();
            key_times.delete();
        end
        n_app = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 12);
        n_q   = $urandom_range(3, 16);
        fk    = rand_frame();
        tk    = rand_time();
        if (fk > FRAME_LIMIT - 9 * n_app)
            fk = FRAME_LIMIT - 9 * n_app;
        if (tk > TIME_LIMIT - longint'(n_app) * 64'h1_0000_0000)
            tk = TIME_LIMIT - longint'(n_app) * 64'h1_0000_0000;
        for (i = 0; i < n_app; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                add_append(rand_frame(), rand_time());
            else
            begin
                add_append(FRAME_W'(fk), TIME_W'(tk));
                // steps of zero give runs of equal keys
                fk = fk + $urandom_range(0, 8);
                tk = tk + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom);
            end
        end
        for (i = 0; i < n_q; i++)
            add_query();
    endtask

    function automatic int idle_phase();
        if (sent_count * 3 < total_requests)
            return 0;
        if (sent_count * 3 < total_requests * 2)
            return 1;
        return 2;
    endfunction

    // driver: offers the next request on the falling edge, holds it until taken
    always @(negedge clk)
    begin : driver
        request_t nxt;
        logic     idle;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            case (idle_phase())
                0: idle = ($urandom_range(0, 99) < 23);
                1: idle = ($urandom_range(0, 99) < 71);
                default: idle = 1'b0;
            endcase
            if (pending_requests.size() != 0 && !idle)
            begin
                nxt = pending_requests.pop_front();
                s_tdata  <= IN_DATA_W'({nxt.tim, nxt.tim_v, nxt.frm, nxt.frm_v,
                                        nxt.idx, nxt.idx_v});
                s_tuser  <= nxt.cmd;
                s_tvalid <= 1'b1;
                sent_count++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random back-pressure, plus one long hold-off in the final phase
    // so that a finished lookup sits in the block and the request side stalls
    always @(negedge clk)
    begin : receiver
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && idle_phase() == 2 && sent_count > total_requests - 150)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            case (idle_phase())
                0: m_tready <= ($urandom_range(0, 99) >= 71);
                1: m_tready <= ($urandom_range(0, 99) >= 23);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // monitor: checks each lookup against the oldest owed one, then predicts
    // the lookup for any request taken at this edge
    always @(posedge clk)
    begin : monitor
        lookup_t  got;
        lookup_t  want;
        request_t taken;
        req_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ok  = m_tuser[0];
            got.idx = m_tdata[0 +: IDX_W];
            got.frm = m_tdata[IDX_W +: FRAME_W];
            got.tim = m_tdata[IDX_W + FRAME_W +: TIME_W];
            got.cnt = m_tdata[IDX_W + FRAME_W + TIME_W +: COUNT_W];
            if (owed_lookups.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: lookup with none owed, expected nothing, actual %h",
                             $time, got);
            end
            else
            begin
                want = owed_lookups.pop_front();
                if (got.ok !== want.ok)
                    flag_field("ok", TIME_W'(want.ok), TIME_W'(got.ok));
                if (got.idx !== want.idx)
                    flag_field("found_index", TIME_W'(want.idx), TIME_W'(got.idx));
                if (got.frm !== want.frm)
                    flag_field("found_frame", TIME_W'(want.frm), TIME_W'(got.frm));
                if (got.tim !== want.tim)
                    flag_field("found_time", want.tim, got.tim);
                if (got.cnt !== want.cnt)
                    flag_field("entry_count", TIME_W'(want.cnt), TIME_W'(got.cnt));
            end
        end
        if (req_taken)
        begin
            taken.cmd   = s_tuser;
            taken.idx_v = s_tdata[0];
            taken.idx   = s_tdata[1 +: IDX_W];
            taken.frm_v = s_tdata[1 + IDX_W];
            taken.frm   = s_tdata[2 + IDX_W +: FRAME_W];
            taken.tim_v = s_tdata[2 + IDX_W + FRAME_W];
            taken.tim   = s_tdata[3 + IDX_W + FRAME_W +: TIME_W];
            owed_lookups.insert(owed_lookups.size(), apply_request(taken));
        end
    end

    initial
    begin : stimulus
        int i;
        int mark;

        // empty table, no key, unknown command
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b0, '0, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b1, '0, 1'b0, '0, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b1, '0, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b0, '0, 1'b1, TIME_TOP);
        add_req(CMD_UNKNOWN, 1'b1, '1, 1'b1, FRAME_TOP, 1'b1, TIME_TOP);
        // table: (0,0) (10,1000) (10,1000) (max,max)
        add_req(CMD_APPEND, 1'b0, '0, 1'b0, '0, 1'b0, '0);
        add_req(CMD_APPEND, 1'b1, '1, 1'b1, 31'd10, 1'b1, 63'd1000);
        add_req(CMD_APPEND, 1'b0, '0, 1'b0, 31'd10, 1'b0, 63'd1000);
        add_req(CMD_APPEND, 1'b0, '0, 1'b0, FRAME_TOP, 1'b0, TIME_TOP);
        // direct index inside and outside the fill level
        add_req(CMD_RESOLVE, 1'b1, 10'd0, 1'b0, '0, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b1, 10'd3, 1'b0, '0, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b1, 10'd4, 1'b0, '0, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b1, '1, 1'b0, '0, 1'b0, '0);
        // floor on frames: equal keys, between keys, at the last key
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b1, 31'd10, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b1, 31'd9, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b1, FRAME_TOP, 1'b0, '0);
        // floor on times
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b0, '0, 1'b1, 63'd0);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b0, '0, 1'b1, 63'd999);
        // key priority: index over frame over time
        add_req(CMD_RESOLVE, 1'b1, 10'd1, 1'b1, 31'd0, 1'b1, TIME_TOP);
        add_req(CMD_RESOLVE, 1'b0, '1, 1'b1, 31'd10, 1'b1, 63'd0);
        // no key flagged, junk in the values
        add_req(CMD_RESOLVE, 1'b0, '1, 1'b0, FRAME_TOP, 1'b0, TIME_TOP);
        // before the first entry
        add_req(CMD_CLEAR, 1'b0, '0, 1'b0, '0, 1'b0, '0);
        add_req(CMD_APPEND, 1'b0, '0, 1'b0, 31'd50, 1'b0, 63'd500);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b1, 31'd49, 1'b0, '0);
        add_req(CMD_RESOLVE, 1'b0, '0, 1'b0, '0, 1'b1, 63'd499);

        mark = pending_requests.size();
        while (pending_requests.size() - mark < 20)
            build_run();

        // fill the table to the brim, then appends that must be refused
        add_req(CMD_CLEAR, 1'b0, '0, 1'b0, '0, 1'b0, '0);
        key_frames.delete();
        key_times.delete();
        for (i = 0; i < TABLE_DEPTH; i++)
            add_append(FRAME_W'(i * 3), TIME_W'(64'h4000_0000_0000_0000 + i * 5));
        add_append(rand_frame(), rand_time());
        add_append(FRAME_TOP, TIME_TOP);
        add_req(CMD_RESOLVE, 1'b1, 10'd1023, 1'b0, '0, 1'b0, '0);
        for (i = 0; i < 12; i++)
            add_query();

        mark = pending_requests.size();
        while (pending_requests.size() - mark < 20)
            build_run();

        total_requests = pending_requests.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid)
            @(posedge clk);
        while (owed_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d appends stored, %0d refused on a full table,",
                 total_requests, n_appends, n_refused);
        $display("%0d clears, %0d resolves with %0d entries found, %0d unknown commands; %0d mismatches.",
                 n_clears, n_resolves, n_hits, n_unknown, fail_count);
        if (fail_count == 0 && owed_lookups.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog: roughly twenty times the slowest legitimate run
    initial
    begin : watchdog
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
